// File: design/gpm_pkg.sv
// Shared types, constants and helpers for the glob pattern matcher.
// Used by gpm_lanes and glob_pattern_matcher; depends on nothing else.
`default_nettype none

package gpm_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int POS_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int NPOS        = MAX_PATTERN + 1;

  localparam logic [7:0] STAR_CH   = 8'h2A;
  localparam logic [7:0] QMARK_CH  = 8'h3F;
  localparam logic [7:0] UPPER_A   = 8'h41;
  localparam logic [7:0] UPPER_Z   = 8'h5A;
  localparam logic [7:0] CASE_BIAS = 8'h20;

  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_SUBJECT = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] ch;
    logic       has_char;
    logic       last;
  } in_req_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } out_rsp_t;

  typedef struct packed {
    logic             en;
    logic [POS_W-1:0] idx;
    logic [7:0]       ch;
  } lane_wr_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= UPPER_A && c <= UPPER_Z) begin
      return c + CASE_BIAS;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: design/gpm_lanes.sv
// Pattern lanes: one stored pattern byte per position plus the NFA step and
// star closure of the active vector. Depends on gpm_pkg.
`default_nettype none

module gpm_lanes (
  input  logic                         clk,
  input  gpm_pkg::lane_wr_t            wr,
  input  logic [gpm_pkg::LEN_W-1:0]    len,
  input  logic [7:0]                   ch,
  input  logic [gpm_pkg::NPOS-1:0]     act,
  output logic [gpm_pkg::NPOS-1:0]     act_nxt
);
  import gpm_pkg::*;

  logic [7:0]             fold_r [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] star_r;
  logic [MAX_PATTERN-1:0] qmark_r;

  logic [7:0]             lc;
  logic [MAX_PATTERN-1:0] live;
  logic [MAX_PATTERN-1:0] hit;
  logic [MAX_PATTERN-1:0] spin;
  logic [MAX_PATTERN-1:0] adv;
  logic [NPOS-1:0]        stepped;
  logic [NPOS-1:0]        star_live;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      fold_r[wr.idx]  <= fold_case(wr.ch);
      star_r[wr.idx]  <= (wr.ch == STAR_CH);
      qmark_r[wr.idx] <= (wr.ch == QMARK_CH);
    end
  end

  always_comb begin
    lc = fold_case(ch);
    for (int i = 0; i < MAX_PATTERN; i++) begin
      live[i] = (LEN_W'(i) < len);
      hit[i]  = live[i] && !star_r[i] && (qmark_r[i] || (fold_r[i] == lc));
    end
    spin      = act[MAX_PATTERN-1:0] & live & star_r;
    adv       = act[MAX_PATTERN-1:0] & hit;
    stepped   = {1'b0, spin} | {adv, 1'b0};
    star_live = {1'b0, star_r & live};
    // carry through each run of stars spreads activity to the run's end and the next position
    act_nxt   = stepped | ((star_live + (stepped & star_live)) ^ star_live);
  end

endmodule

`default_nettype wire

// File: design/glob_pattern_matcher.sv
// Top level of the case-insensitive glob matcher: request control, pattern
// state and the result register. Depends on gpm_pkg and gpm_lanes.
//
// Usage: requests enter on in_valid/in_stall/in_data. A pattern request
// (op = pattern) appends one byte to the pattern, up to MAX_PATTERN bytes;
// last closes the pattern. Subject requests then stream one byte per cycle
// while in_stall is low; the request with last set yields one result on
// out_valid/out_stall/out_data (matched, overflow). has_char = 0 with last
// ends a string with no byte; has_char = 0 without last is dropped.
// Result: registered, it appears in the cycle after its last subject request.
// Throughput: one request per cycle while in_stall is low, as the active-
// position vector is updated by combinational logic (per-lane compare plus
// one carry chain over MAX_PATTERN + 1 positions) and registered.
// Reset: empty pattern, only the start position active, no result held.
// Stall: while a result waits and out_stall is high, in_stall is raised and
// all state holds; the result stays on out_data until taken.
`default_nettype none

module glob_pattern_matcher (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gpm_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output gpm_pkg::out_rsp_t out_data
);
  import gpm_pkg::*;

  logic [LEN_W-1:0] len_r, len_nxt;
  logic             tl_r, tl_nxt;
  logic             seen_r, seen_nxt;
  logic             restart_r, restart_nxt;
  logic [NPOS-1:0]  act_r, act_nxt;
  logic [NPOS-1:0]  start_r, start_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_rsp_t         out_data_r, out_data_nxt;

  logic             take;
  logic             pat_req;
  logic             subj_req;
  logic [LEN_W-1:0] base_len;
  logic             base_tl;
  logic [NPOS-1:0]  base_start;
  logic [NPOS-1:0]  lanes_act;
  logic [NPOS-1:0]  stepped_act;
  logic             seen_after;
  logic [NPOS-1:0]  end_mask;
  logic [NPOS-1:0]  reach_mask;
  lane_wr_t         wr;

  gpm_lanes u_lanes (
    .clk     (clk),
    .wr      (wr),
    .len     (len_r),
    .ch      (in_data.ch),
    .act     (act_r),
    .act_nxt (lanes_act)
  );

  assign in_stall  = out_valid_r && out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign take     = in_valid && !in_stall && (in_data.has_char || in_data.last);
  assign pat_req  = take && (in_data.op == OP_PATTERN);
  assign subj_req = take && (in_data.op == OP_SUBJECT);

  assign base_len   = restart_r ? '0 : len_r;
  assign base_tl    = restart_r ? 1'b0 : tl_r;
  assign base_start = restart_r ? NPOS'(1) : start_r;

  assign end_mask   = NPOS'(1) << len_r;
  assign reach_mask = (end_mask << 1) - NPOS'(1);

  assign stepped_act = in_data.has_char ? lanes_act : act_r;
  assign seen_after  = seen_r || in_data.has_char;

  always_comb begin
    len_nxt       = len_r;
    tl_nxt        = tl_r;
    seen_nxt      = seen_r;
    restart_nxt   = restart_r;
    act_nxt       = act_r;
    start_nxt     = start_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    wr            = '0;
    if (pat_req) begin
      len_nxt   = base_len;
      tl_nxt    = base_tl;
      start_nxt = base_start;
      if (in_data.has_char) begin
        if (base_len < LEN_W'(MAX_PATTERN)) begin
          wr.en   = 1'b1;
          wr.idx  = base_len[POS_W-1:0];
          wr.ch   = in_data.ch;
          len_nxt = base_len + LEN_W'(1);
          if (in_data.ch == STAR_CH && base_start[base_len]) begin
            start_nxt[len_nxt] = 1'b1;
          end
        end else begin
          tl_nxt = 1'b1;
        end
      end
      restart_nxt = in_data.last;
      act_nxt     = start_nxt;
      seen_nxt    = 1'b0;
    end else if (subj_req) begin
      restart_nxt = 1'b1;
      if (in_data.last) begin
        out_valid_nxt         = 1'b1;
        out_data_nxt.matched  = (len_r != '0) && !tl_r && seen_after &&
                                (|(stepped_act & end_mask));
        out_data_nxt.overflow = tl_r;
        act_nxt               = start_r;
        seen_nxt              = 1'b0;
      end else begin
        act_nxt  = stepped_act;
        seen_nxt = seen_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      tl_r        <= 1'b0;
      seen_r      <= 1'b0;
      restart_r   <= 1'b1;
      act_r       <= NPOS'(1);
      start_r     <= NPOS'(1);
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      tl_r        <= tl_nxt;
      seen_r      <= seen_nxt;
      restart_r   <= restart_nxt;
      act_r       <= act_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(MAX_PATTERN))
    else $error("pattern length beyond store");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    tl_r |-> (len_r == LEN_W'(MAX_PATTERN)))
    else $error("overflow flagged with store not full");

  a_act_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((act_r & ~reach_mask) == '0) && ((start_r & ~reach_mask) == '0))
    else $error("active position beyond pattern end");

  a_overflow_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.matched && out_data_r.overflow))
    else $error("match reported on overflowed pattern");

endmodule

`default_nettype wire
